// ===== design/radial_zoom_blur_defines.svh =====
// Assertion macros shared by the blur block.
`ifndef RADIAL_ZOOM_BLUR_DEFINES_SVH
`define RADIAL_ZOOM_BLUR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RZB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RZB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rzb_pkg.sv =====
package rzb_pkg;
	localparam int MaxWidth = 256;
	localparam int MaxHeight = 256;
	localparam int MaxTaps = 64;
	localparam int StoreDepth = MaxWidth * MaxHeight;
	localparam int AddrW = $clog2(StoreDepth);
	localparam int DivW = 16;
	localparam int DsorW = 7;

	localparam logic [2:0] REG_WIDTH = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_TAPS = 3'd2;
	localparam logic [2:0] REG_INTENSITY = 3'd3;
	localparam logic [2:0] REG_CENTER_COL = 3'd4;
	localparam logic [2:0] REG_CENTER_ROW = 3'd5;

	localparam logic [10:0] PER_MILLE = 11'd1000;
	localparam logic [12:0] RECIP_1000 = 13'd4195;

	typedef struct packed {
		logic start;
		logic [DivW-1:0] dividend;
		logic [DsorW-1:0] divisor;
	} div_req_t;
endpackage

// ===== design/radial_zoom_blur.sv =====
// Radial zoom blur over an RGBA frame held in an on-chip store.
// Input stream: tuser is the kind (0 load, 1 emit); tdata carries red, green,
// blue and alpha from the lowest byte up. A load beat writes the next pixel
// of the frame in raster order. An emit beat produces the next output
// pixel in raster order on the output stream, with tlast set on the last
// pixel of the frame.
// With one tap or zero intensity an emit presents the stored pixel at its
// position unchanged. Otherwise each tap steps through scale read, two
// multiply stages, correction, clamp, store read and accumulate, a chain of
// dependent steps, and the four channel means are taken one after another
// on the shared serial divider. After reset or a change of tap count or
// intensity, the first emit that blurs also fills the scale table on that
// divider, one entry per tap. Items are taken one at a time; the input is
// ready only while no emit is in progress.
// Reset clears the load and emit positions and the registers to their
// defaults; the frame store holds no defined data until loaded.
// A finished pixel waits in the output register; loads are still taken
// while it waits, and the next emit holds its result until the register
// is free.
`include "radial_zoom_blur_defines.svh"
module radial_zoom_blur
	import rzb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [9:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata, // red_in, green_in, blue_in, alpha_in
	input logic s_tuser, // kind
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata, // red_out, green_out, blue_out, alpha_out
	output logic m_tlast
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SETUP = 4'd1;
	localparam logic [3:0] ST_SC_START = 4'd2;
	localparam logic [3:0] ST_SC_WAIT = 4'd3;
	localparam logic [3:0] ST_TAP_RD = 4'd4;
	localparam logic [3:0] ST_TAP_MUL = 4'd5;
	localparam logic [3:0] ST_TAP_REC = 4'd6;
	localparam logic [3:0] ST_TAP_COR = 4'd7;
	localparam logic [3:0] ST_TAP_CLP = 4'd8;
	localparam logic [3:0] ST_TAP_ADR = 4'd9;
	localparam logic [3:0] ST_TAP_ACC = 4'd10;
	localparam logic [3:0] ST_DIV_START = 4'd11;
	localparam logic [3:0] ST_DIV_WAIT = 4'd12;
	localparam logic [3:0] ST_ID_WAIT = 4'd13;
	localparam logic [3:0] ST_FIN = 4'd14;

	logic [8:0] w_cfg_q, h_cfg_q;
	logic [6:0] n_cfg_q;
	logic [9:0] i_cfg_q;
	logic [7:0] cx_cfg_q, cy_cfg_q;

	logic [8:0] w_eff, h_eff;
	logic [6:0] n_eff;
	logic [9:0] inten;
	logic [7:0] w_m1, h_m1, cx_eff, cy_eff;
	logic [5:0] nm1;
	logic [16:0] total;
	logic ident;

	logic [3:0] st_q;
	logic dirty_q;
	logic [AddrW-1:0] load_q;
	logic [7:0] ecol_q, erow_q;
	logic [7:0] x_q, y_q;
	logic signed [8:0] dx_q, dy_q;
	logic [5:0] i_q;
	logic [1:0] c_q;
	logic sneg_q;
	logic [13:0] sum_q [4];
	logic [31:0] res_q;

	logic [10:0] scale_mem [MaxTaps];
	logic [10:0] scale_rd_q;
	logic sc_we;
	logic [10:0] sc_val;

	logic signed [20:0] px_s1, py_s1;
	logic [18:0] magx_s2, magy_s2;
	logic [9:0] q0x_s2, q0y_s2;
	logic negx_s2, negy_s2;
	logic signed [10:0] offx_s3, offy_s3;
	logic [7:0] tx_q, ty_q;

	logic s_fire, fin_go;
	logic [16:0] ld_idx, ld_nxt;
	logic signed [7:0] k;
	logic signed [18:0] kp;
	logic [15:0] kmag;
	logic [18:0] magx, magy;
	logic [31:0] recx, recy;
	logic [19:0] chkx, chky;
	logic [9:0] qx, qy;
	logic signed [11:0] sx, sy;
	logic [7:0] row_sel, col_sel;
	logic [16:0] addr_full;
	logic rd_en;
	logic [31:0] rd_data;
	div_req_t div_req;
	logic div_done;
	logic [DivW-1:0] div_q;
	logic o_valid_q;
	logic [31:0] o_data_q;
	logic o_last_q;

	always_comb begin
		w_eff = (w_cfg_q == 9'd0) ? 9'd1 : ((w_cfg_q > 9'(MaxWidth)) ? 9'(MaxWidth) : w_cfg_q);
		h_eff = (h_cfg_q == 9'd0) ? 9'd1 : ((h_cfg_q > 9'(MaxHeight)) ? 9'(MaxHeight) : h_cfg_q);
		n_eff = (n_cfg_q == 7'd0) ? 7'd1 : ((n_cfg_q > 7'(MaxTaps)) ? 7'(MaxTaps) : n_cfg_q);
		inten = (i_cfg_q > 10'd1000) ? 10'd1000 : i_cfg_q;
		w_m1 = 8'(w_eff - 9'd1);
		h_m1 = 8'(h_eff - 9'd1);
		cx_eff = (cx_cfg_q > w_m1) ? w_m1 : cx_cfg_q;
		cy_eff = (cy_cfg_q > h_m1) ? h_m1 : cy_cfg_q;
		nm1 = 6'(n_eff - 7'd1);
		total = {8'd0, w_eff} * {8'd0, h_eff};
		ident = (n_eff == 7'd1) || (inten == 10'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_cfg_q <= 9'd256;
			h_cfg_q <= 9'd256;
			n_cfg_q <= 7'd1;
			i_cfg_q <= 10'd0;
			cx_cfg_q <= 8'd0;
			cy_cfg_q <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH: w_cfg_q <= cfg_data[8:0];
				REG_HEIGHT: h_cfg_q <= cfg_data[8:0];
				REG_TAPS: n_cfg_q <= cfg_data[6:0];
				REG_INTENSITY: i_cfg_q <= cfg_data;
				REG_CENTER_COL: cx_cfg_q <= cfg_data[7:0];
				REG_CENTER_ROW: cy_cfg_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign s_tready = (st_q == ST_IDLE);
	assign s_fire = s_tvalid && s_tready;
	assign fin_go = (st_q == ST_FIN) && (!o_valid_q || m_tready);

	assign ld_idx = ({1'b0, load_q} >= total) ? 17'd0 : {1'b0, load_q};
	assign ld_nxt = ld_idx + 17'd1;

	assign k = $signed({1'b0, i_q, 1'b0}) - $signed({2'b0, nm1});
	assign kp = 19'(k) * 19'($signed({1'b0, inten}));
	assign kmag = (kp < 0) ? 16'(-kp) : 16'(kp);

	assign magx = (px_s1 < 0) ? 19'(-px_s1) : 19'(px_s1);
	assign magy = (py_s1 < 0) ? 19'(-py_s1) : 19'(py_s1);
	assign recx = {13'd0, magx} * {19'd0, RECIP_1000};
	assign recy = {13'd0, magy} * {19'd0, RECIP_1000};
	assign chkx = {10'd0, q0x_s2} * {9'd0, PER_MILLE};
	assign chky = {10'd0, q0y_s2} * {9'd0, PER_MILLE};
	assign qx = (chkx > {1'b0, magx_s2}) ? q0x_s2 - 10'd1 : q0x_s2;
	assign qy = (chky > {1'b0, magy_s2}) ? q0y_s2 - 10'd1 : q0y_s2;
	assign sx = $signed({4'd0, cx_eff}) + 12'(offx_s3);
	assign sy = $signed({4'd0, cy_eff}) + 12'(offy_s3);

	assign sc_we = (st_q == ST_SC_WAIT) && div_done;
	assign sc_val = sneg_q ? PER_MILLE - div_q[10:0] : PER_MILLE + div_q[10:0];

	always_ff @(posedge clk) begin
		if (sc_we) begin
			scale_mem[i_q] <= sc_val;
		end
		if (st_q == ST_TAP_RD) begin
			scale_rd_q <= scale_mem[i_q];
		end
	end

	assign row_sel = (st_q == ST_SETUP) ? y_q : ty_q;
	assign col_sel = (st_q == ST_SETUP) ? x_q : tx_q;
	assign addr_full = {9'd0, row_sel} * {8'd0, w_eff} + {9'd0, col_sel};
	assign rd_en = ((st_q == ST_SETUP) && ident) || (st_q == ST_TAP_ADR);

	rzb_store u_store (
		.clk(clk),
		.we(s_fire && !s_tuser),
		.waddr(ld_idx[AddrW-1:0]),
		.wdata(s_tdata),
		.re(rd_en),
		.raddr(addr_full[AddrW-1:0]),
		.rdata(rd_data)
	);

	always_comb begin
		div_req.start = (st_q == ST_SC_START) || (st_q == ST_DIV_START);
		if (st_q == ST_SC_START) begin
			div_req.dividend = kmag;
			div_req.divisor = {1'b0, nm1};
		end else begin
			div_req.dividend = {2'b0, sum_q[c_q]} + {10'd0, n_eff[6:1]};
			div_req.divisor = n_eff;
		end
	end

	rzb_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.done(div_done),
		.quot(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			dirty_q <= 1'b1;
			load_q <= '0;
			ecol_q <= '0;
			erow_q <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == REG_TAPS || cfg_index == REG_INTENSITY)) begin
				dirty_q <= 1'b1;
			end else if (sc_we && (i_q == nm1)) begin
				dirty_q <= 1'b0;
			end
			if (fin_go) begin
				o_valid_q <= 1'b1;
			end else if (m_tready) begin
				o_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (s_fire) begin
						if (!s_tuser) begin
							load_q <= (ld_nxt >= total) ? '0 : ld_nxt[AddrW-1:0];
						end else begin
							st_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					if (ident) begin
						st_q <= ST_ID_WAIT;
					end else if (dirty_q) begin
						st_q <= ST_SC_START;
					end else begin
						st_q <= ST_TAP_RD;
					end
				end
				ST_SC_START: st_q <= ST_SC_WAIT;
				ST_SC_WAIT: begin
					if (div_done) begin
						if (i_q == nm1) begin
							st_q <= ST_TAP_RD;
						end else begin
							st_q <= ST_SC_START;
						end
					end
				end
				ST_TAP_RD: st_q <= ST_TAP_MUL;
				ST_TAP_MUL: st_q <= ST_TAP_REC;
				ST_TAP_REC: st_q <= ST_TAP_COR;
				ST_TAP_COR: st_q <= ST_TAP_CLP;
				ST_TAP_CLP: st_q <= ST_TAP_ADR;
				ST_TAP_ADR: st_q <= ST_TAP_ACC;
				ST_TAP_ACC: st_q <= (i_q == nm1) ? ST_DIV_START : ST_TAP_RD;
				ST_DIV_START: st_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						st_q <= (c_q == 2'd3) ? ST_FIN : ST_DIV_START;
					end
				end
				ST_ID_WAIT: st_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						st_q <= ST_IDLE;
						if (x_q == w_m1) begin
							ecol_q <= '0;
							erow_q <= (y_q == h_m1) ? 8'd0 : y_q + 8'd1;
						end else begin
							ecol_q <= x_q + 8'd1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				x_q <= ({1'b0, ecol_q} >= w_eff) ? 8'd0 : ecol_q;
				y_q <= ({1'b0, erow_q} >= h_eff) ? 8'd0 : erow_q;
			end
			ST_SETUP: begin
				dx_q <= $signed({1'b0, x_q}) - $signed({1'b0, cx_eff});
				dy_q <= $signed({1'b0, y_q}) - $signed({1'b0, cy_eff});
				i_q <= '0;
				c_q <= '0;
				for (int j = 0; j < 4; j++) begin
					sum_q[j] <= '0;
				end
			end
			ST_SC_START: sneg_q <= (k < 0);
			ST_SC_WAIT: begin
				if (div_done) begin
					i_q <= (i_q == nm1) ? 6'd0 : i_q + 6'd1;
				end
			end
			ST_TAP_MUL: begin
				px_s1 <= 21'(dx_q) * 21'($signed({1'b0, scale_rd_q}));
				py_s1 <= 21'(dy_q) * 21'($signed({1'b0, scale_rd_q}));
			end
			ST_TAP_REC: begin
				magx_s2 <= magx;
				magy_s2 <= magy;
				q0x_s2 <= recx[31:22];
				q0y_s2 <= recy[31:22];
				negx_s2 <= (px_s1 < 0);
				negy_s2 <= (py_s1 < 0);
			end
			ST_TAP_COR: begin
				offx_s3 <= negx_s2 ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
				offy_s3 <= negy_s2 ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
			end
			ST_TAP_CLP: begin
				tx_q <= (sx < 0) ? 8'd0 : ((sx > $signed({4'd0, w_m1})) ? w_m1 : sx[7:0]);
				ty_q <= (sy < 0) ? 8'd0 : ((sy > $signed({4'd0, h_m1})) ? h_m1 : sy[7:0]);
			end
			ST_TAP_ACC: begin
				for (int j = 0; j < 4; j++) begin
					sum_q[j] <= sum_q[j] + {6'd0, rd_data[8*j +: 8]};
				end
				i_q <= i_q + 6'd1;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					res_q[8*c_q +: 8] <= div_q[7:0];
					c_q <= c_q + 2'd1;
				end
			end
			ST_ID_WAIT: res_q <= rd_data;
			ST_FIN: begin
				if (fin_go) begin
					o_data_q <= res_q;
					o_last_q <= (x_q == w_m1) && (y_q == h_m1);
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata = o_data_q;
	assign m_tlast = o_last_q;

	`RZB_ASSERT_NEXT(a_fin_out, fin_go, o_valid_q, "finished pixel not presented")
	`RZB_ASSERT_IMPL(a_load_idle, s_fire && !s_tuser, st_q == ST_IDLE, "load while emitting")
	`RZB_ASSERT_IMPL(a_div_owner, div_done, st_q == ST_SC_WAIT || st_q == ST_DIV_WAIT, "stray quotient")
endmodule

// ===== design/rzb_store.sv =====
module rzb_store
	import rzb_pkg::*;
(
	input logic clk,
	input logic we,
	input logic [AddrW-1:0] waddr,
	input logic [31:0] wdata,
	input logic re,
	input logic [AddrW-1:0] raddr,
	output logic [31:0] rdata
);
	logic [31:0] mem [StoreDepth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== design/rzb_div.sv =====
`include "radial_zoom_blur_defines.svh"
module rzb_div
	import rzb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output logic done,
	output logic [DivW-1:0] quot
);
	logic [DivW-1:0] dvd_q;
	logic [DsorW-1:0] rem_q;
	logic [DsorW-1:0] dsor_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DsorW:0] trial;
	logic ge;
	logic [DsorW:0] diff;

	assign trial = {rem_q, dvd_q[DivW-1]};
	assign ge = trial >= {1'b0, dsor_q};
	assign diff = trial - {1'b0, dsor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsor_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DivW-2:0], ge};
			rem_q <= ge ? diff[DsorW-1:0] : trial[DsorW-1:0];
		end
	end

	assign done = done_q;
	assign quot = dvd_q;

	`RZB_ASSERT_IMPL(a_start_idle, req.start, !busy_q, "divider started while busy")
	`RZB_ASSERT_NEXT(a_done_end, busy_q && cnt_q == 5'd1 && !req.start, done_q, "divider lost done")
endmodule

// ===== verif/tb_radial_zoom_blur.sv =====
`timescale 1ns / 100ps
module tb_radial_zoom_blur;
	import rzb_pkg::*;

	localparam int StallLimit = 20000;
	localparam int SettleCycles = 40;
	localparam int RandomItems = 380;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic frame_end;
	} pixel_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic m_tlast;

	radial_zoom_blur u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #6 clk = ~clk;

	logic [31:0] pixel_mem [StoreDepth];
	int width_reg = 256;
	int height_reg = 256;
	int taps_reg = 1;
	int intensity_reg = 0;
	int ccol_reg = 0;
	int crow_reg = 0;
	int load_pos = 0;
	int emit_x = 0;
	int emit_y = 0;

	pixel_out_t blurred_q[$];
	int errors = 0;
	int items_sent = 0;
	int stall_count = 0;
	bit calm = 1'b0;

	function automatic int clampi(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int eff_w();
		return width_reg == 0 ? 1 : (width_reg > MaxWidth ? MaxWidth : width_reg);
	endfunction

	function automatic int eff_h();
		return height_reg == 0 ? 1 : (height_reg > MaxHeight ? MaxHeight : height_reg);
	endfunction

	function automatic void predict_blur(logic kind, logic [31:0] data);
		int w, h, total, idx, n, inten, cx, cy, dx, dy, nm1, s, tx, ty, x, y;
		int sum [4];
		logic [31:0] word, pix;
		pixel_out_t res;
		w = eff_w();
		h = eff_h();
		total = w * h;
		if (kind == 1'b0) begin
			idx = load_pos;
			if (idx >= total) idx = 0;
			pixel_mem[idx] = data;
			idx++;
			load_pos = idx >= total ? 0 : idx;
			return;
		end
		if (emit_x >= w) emit_x = 0;
		if (emit_y >= h) emit_y = 0;
		x = emit_x;
		y = emit_y;
		n = taps_reg == 0 ? 1 : (taps_reg > MaxTaps ? MaxTaps : taps_reg);
		inten = intensity_reg > 1000 ? 1000 : intensity_reg;
		if (n == 1 || inten == 0) begin
			pix = pixel_mem[y * w + x];
		end else begin
			nm1 = n - 1;
			cx = clampi(ccol_reg, 0, w - 1);
			cy = clampi(crow_reg, 0, h - 1);
			dx = x - cx;
			dy = y - cy;
			for (int c = 0; c < 4; c++) sum[c] = 0;
			for (int i = 0; i < n; i++) begin
				s = 1000 + ((2 * i - nm1) * inten) / nm1;
				tx = clampi(cx + (dx * s) / 1000, 0, w - 1);
				ty = clampi(cy + (dy * s) / 1000, 0, h - 1);
				word = pixel_mem[ty * w + tx];
				for (int c = 0; c < 4; c++) sum[c] += word[8*c +: 8];
			end
			for (int c = 0; c < 4; c++) pix[8*c +: 8] = 8'((sum[c] + n / 2) / n);
		end
		res.red = pix[7:0];
		res.green = pix[15:8];
		res.blue = pix[23:16];
		res.alpha = pix[31:24];
		res.frame_end = (x == w - 1 && y == h - 1);
		blurred_q.push_back(res);
		if (x + 1 >= w) begin
			emit_x = 0;
			emit_y = (y + 1 >= h) ? 0 : y + 1;
		end else begin
			emit_x = x + 1;
		end
	endfunction

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 21);
	end

	always @(posedge clk) begin
		pixel_out_t exp_px;
		if (arst_n && m_tvalid && m_tready) begin
			if (blurred_q.size() == 0) begin
				$error("unexpected output beat %h", m_tdata);
				errors++;
			end else begin
				exp_px = blurred_q.pop_front();
				if (m_tdata[7:0] !== exp_px.red) begin
					$error("red_out expected %h actual %h", exp_px.red, m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[15:8] !== exp_px.green) begin
					$error("green_out expected %h actual %h", exp_px.green, m_tdata[15:8]);
					errors++;
				end
				if (m_tdata[23:16] !== exp_px.blue) begin
					$error("blue_out expected %h actual %h", exp_px.blue, m_tdata[23:16]);
					errors++;
				end
				if (m_tdata[31:24] !== exp_px.alpha) begin
					$error("alpha_out expected %h actual %h", exp_px.alpha, m_tdata[31:24]);
					errors++;
				end
				if (m_tlast !== exp_px.frame_end) begin
					$error("frame_end expected %b actual %b", exp_px.frame_end, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			stall_count <= 0;
		end else begin
			stall_count <= stall_count + 1;
			if (stall_count >= StallLimit) begin
				$display("radial_zoom_blur: mismatch");
				$finish;
			end
		end
	end

	task automatic send_item(logic kind, logic [31:0] data);
		while (!calm && $urandom_range(99) < 21) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = data;
		do @(posedge clk); while (!s_tready);
		predict_blur(kind, data);
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (blurred_q.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int value);
		wait_drained();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value[9:0];
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_WIDTH: width_reg = value & 'h1FF;
			REG_HEIGHT: height_reg = value & 'h1FF;
			REG_TAPS: taps_reg = value & 'h7F;
			REG_INTENSITY: intensity_reg = value & 'h3FF;
			REG_CENTER_COL: ccol_reg = value & 'hFF;
			default: crow_reg = value & 'hFF;
		endcase
	endtask

	task automatic set_blur(int w, int h, int n, int inten, int cc, int cr);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_TAPS, n);
		write_reg(REG_INTENSITY, inten);
		write_reg(REG_CENTER_COL, cc);
		write_reg(REG_CENTER_ROW, cr);
	endtask

	// Loading one full frame from any position covers every in-frame entry.
	task automatic load_frame();
		int total;
		total = eff_w() * eff_h();
		for (int i = 0; i < total; i++) send_item(1'b0, $urandom());
	endtask

	task automatic test_identity();
		set_blur(4, 2, 1, 0, 0, 0);
		send_item(1'b0, 32'h0000_0000);
		send_item(1'b0, 32'hFFFF_FFFF);
		for (int i = 2; i < 8; i++) send_item(1'b0, $urandom());
		for (int i = 0; i < 9; i++) send_item(1'b1, $urandom());
	endtask

	task automatic test_limits();
		set_blur(0, 0, 0, 1023, 255, 255);
		send_item(1'b0, 32'hA5A5_5A5A);
		send_item(1'b1, 32'hFFFF_FFFF);
		send_item(1'b1, 32'h0);
		set_blur(511, 1, 127, 1000, 255, 0);
		load_frame();
		for (int i = 0; i < 3; i++) send_item(1'b1, $urandom());
		set_blur(1, 256, 64, 1, 0, 200);
		load_frame();
		for (int i = 0; i < 2; i++) send_item(1'b1, $urandom());
		set_blur(7, 5, 2, 1000, 3, 2);
		send_item(1'b1, 32'h0);
		send_item(1'b1, 32'h0);
	endtask

	task automatic test_random_frames();
		int target, w, h, n, mix;
		target = items_sent + RandomItems;
		while (items_sent < target) begin
			calm = ($urandom_range(9) == 0);
			w = ($urandom_range(15) == 0) ? $urandom_range(511) : $urandom_range(1, 9);
			h = ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(1, 9);
			if (w * h > 512) h = 1;
			n = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(1, 16);
			set_blur(w, h, n, $urandom_range(1023), $urandom_range(255),
				$urandom_range(12));
			if (w != 0 && h != 0 && $urandom_range(3) == 0) begin
				write_reg(REG_CENTER_COL, $urandom_range(w - 1));
				write_reg(REG_CENTER_ROW, $urandom_range(h - 1));
			end
			load_frame();
			mix = $urandom_range(20, 60);
			for (int i = 0; i < mix; i++) send_item($urandom_range(1), $urandom());
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_identity();
		test_limits();
		test_random_frames();
		wait_drained();
		if (errors == 0) begin
			$display("radial_zoom_blur: match");
		end else begin
			$display("radial_zoom_blur: mismatch");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+design
design/rzb_pkg.sv
design/rzb_store.sv
design/rzb_div.sv
design/radial_zoom_blur.sv
verif/tb_radial_zoom_blur.sv
